@@ sv/tslb_pkg.sv @@
// Shared types and constants for the texture slot LRU binder.
package tslb_pkg;

  localparam int TEX_W      = 32;
  localparam int CFG_W      = 5;
  localparam int SLOT_OUT_W = 4;
  localparam int REQ_W      = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_OCCUPY = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PROBE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture the accepted transaction
    logic compare;  // register tag match and LRU vectors
    logic update;   // resolve slot, update ranks and table, load result
  } cmd_t;

endpackage

@@ sv/tslb_ctrl.sv @@
// Request sequencer: capture, compare and update steps plus the output handshake.
module tslb_ctrl
  import tslb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  state_t state_r;
  logic   in_stall_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd         = '0;
    cmd.load    = (state_r == ST_IDLE) && in_valid;
    cmd.compare = (state_r == ST_CMP);
    cmd.update  = (state_r == ST_UPD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r    <= ST_CMP;
            in_stall_r <= 1'b1;
          end
        end
        ST_CMP: begin
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          // hold until the previous result has been taken
          if (out_free) begin
            state_r    <= ST_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_stall_r <= 1'b0;
        end
      endcase

      if (cmd.update) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

endmodule

@@ sv/tslb_datapath.sv @@
// Slot table, recency ranks, fill count, tag compare and result registers.
module tslb_datapath
  import tslb_pkg::*;
#(
  parameter int MAX_SLOTS = 16
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [TEX_W-1:0]      in_texture_id,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output logic [SLOT_OUT_W-1:0] out_slot_index,
  output logic                  out_was_bound,
  output logic                  out_found
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int RW = IW;

  logic [CFG_W-1:0]     cfg_r;
  logic [REQ_W-1:0]     req_r;
  logic [TEX_W-1:0]     id_r;
  logic [TEX_W-1:0]     tex_r [MAX_SLOTS];
  logic [RW-1:0]        rank_r [MAX_SLOTS];
  logic [RW-1:0]        rank_nxt [MAX_SLOTS];
  logic [CW-1:0]        filled_r;
  logic [CW-1:0]        filled_nxt;
  logic [MAX_SLOTS-1:0] match_r;
  logic [MAX_SLOTS-1:0] match_nxt;
  logic [MAX_SLOTS-1:0] lru_r;
  logic [MAX_SLOTS-1:0] lru_nxt;
  logic [MAX_SLOTS-1:0] fill_mask;

  logic [SLOT_OUT_W-1:0] slot_r;
  logic                  bound_r;
  logic                  found_r;

  // update-step signals
  logic                 hit_any;
  logic [MAX_SLOTS-1:0] hit_oh;
  logic [MAX_SLOTS-1:0] lru_oh;
  logic [MAX_SLOTS-1:0] fill_oh;
  logic [MAX_SLOTS-1:0] sel_oh;
  logic [MAX_SLOTS-1:0] tex_we;
  logic [CW-1:0]        usable;
  logic                 can_fill;
  logic                 promote;
  logic [RW-1:0]        old_rank;
  logic [IW-1:0]        sel_idx;
  logic                 bound_nxt;
  logic                 found_nxt;

  // Tag compare and LRU slot detection over the filled slots
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      fill_mask[i] = CW'(i) < filled_r;
      match_nxt[i] = fill_mask[i] && (tex_r[i] == id_r);
      lru_nxt[i]   = fill_mask[i] && (rank_r[i] == '0);
    end
  end

  always_comb begin
    if (cfg_r == '0) begin
      usable = CW'(1);
    end else if (32'(cfg_r) > 32'(MAX_SLOTS)) begin
      usable = CW'(MAX_SLOTS);
    end else begin
      usable = CW'(cfg_r);
    end
  end

  assign can_fill = filled_r < usable;
  assign hit_any  = |match_r;
  assign hit_oh   = match_r & (~match_r + MAX_SLOTS'(1));

  always_comb begin
    if (lru_r == '0) begin
      lru_oh = MAX_SLOTS'(1);
    end else begin
      lru_oh = lru_r & (~lru_r + MAX_SLOTS'(1));
    end
    for (int i = 0; i < MAX_SLOTS; i++) begin
      fill_oh[i] = CW'(i) == filled_r;
    end
  end

  always_comb begin
    sel_oh     = '0;
    tex_we     = '0;
    promote    = 1'b0;
    bound_nxt  = 1'b0;
    found_nxt  = 1'b0;
    filled_nxt = filled_r;
    old_rank   = '0;
    sel_idx    = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      rank_nxt[i] = rank_r[i];
    end

    case (req_r)
      REQ_OCCUPY: begin
        found_nxt = 1'b1;
        if (hit_any) begin
          sel_oh    = hit_oh;
          promote   = 1'b1;
          bound_nxt = 1'b1;
        end else if (can_fill) begin
          sel_oh     = fill_oh;
          tex_we     = fill_oh;
          filled_nxt = CW'(filled_r + 1'b1);
          for (int i = 0; i < MAX_SLOTS; i++) begin
            if (fill_oh[i]) rank_nxt[i] = RW'(filled_r);
          end
        end else begin
          // evict the least recently used slot
          sel_oh  = lru_oh;
          tex_we  = lru_oh;
          promote = 1'b1;
        end
      end
      REQ_PROBE: begin
        if (hit_any) begin
          sel_oh    = hit_oh;
          bound_nxt = 1'b1;
          found_nxt = 1'b1;
        end
      end
      REQ_CLEAR: begin
        filled_nxt = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
          rank_nxt[i] = '0;
        end
      end
      default: begin
      end
    endcase

    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (sel_oh[i]) begin
        old_rank = old_rank | rank_r[i];
        sel_idx  = sel_idx | IW'(i);
      end
    end

    // make the chosen slot most recent; newer slots drop one rank
    if (promote) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (fill_mask[i] && (rank_r[i] > old_rank)) rank_nxt[i] = rank_r[i] - 1'b1;
        if (sel_oh[i]) rank_nxt[i] = RW'(filled_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r    <= CFG_RESET;
      filled_r <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_we) cfg_r <= cfg_wdata;
      if (cmd.update) begin
        filled_r <= filled_nxt;
        for (int i = 0; i < MAX_SLOTS; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      id_r  <= in_texture_id;
    end
    if (cmd.compare) begin
      match_r <= match_nxt;
      lru_r   <= lru_nxt;
    end
    if (cmd.update) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (tex_we[i]) tex_r[i] <= id_r;
      end
      slot_r  <= SLOT_OUT_W'(sel_idx);
      bound_r <= bound_nxt;
      found_r <= found_nxt;
    end
  end

  assign out_slot_index = slot_r;
  assign out_was_bound  = bound_r;
  assign out_found      = found_r;

endmodule

@@ sv/texture_slot_lru_binder.sv @@
// Texture slot binder: fully associative slot table with least-recently-used replacement.
//
// A transaction passes through capture, compare and update steps. The accepting cycle
// captures it, the next registers a parallel identifier compare against every filled
// slot, and the update step selects the slot, updates the recency ranks and the table
// and loads the result, which is valid from the following cycle. The controller
// handles one transaction at a time, so in_stall stays high after acceptance until
// the update step completes, and only then is a new transaction taken. Results sit
// in an output register; the next transaction is accepted while a result waits,
// but its final step holds until that result is taken. Clear empties the table in
// one step by zeroing the fill count and ranks. The user must write slots_in_use
// through cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
module texture_slot_lru_binder
  import tslb_pkg::*;
#(
  parameter int MAX_SLOTS = 16
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [TEX_W-1:0]      in_texture_id,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SLOT_OUT_W-1:0] out_slot_index,
  output logic                  out_was_bound,
  output logic                  out_found,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  cmd_t cmd;

  tslb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tslb_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_req_type    (in_req_type),
    .in_texture_id  (in_texture_id),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_slot_index (out_slot_index),
    .out_was_bound  (out_was_bound),
    .out_found      (out_found)
  );

endmodule
